### design/cpltlb_pkg.sv
// ----------------------------------------------------------------------------
// cpltlb_pkg
// Shared types and constants of the core-partitioned TLB: geometry, field
// widths, request codes and the layout of one stored set row.
// ----------------------------------------------------------------------------
package cpltlb_pkg;

  localparam int unsigned SET_TOTAL = 16;
  localparam int unsigned WAY_TOTAL = 4;
  localparam int unsigned VPN_W     = 36;
  localparam int unsigned PFN_W     = 28;
  localparam int unsigned STAMP_W   = 64;
  localparam int unsigned CORE_W    = 2;
  localparam int unsigned CNT_W     = 64;

  localparam int unsigned IDX_W    = $clog2(SET_TOTAL + 1) - 1;
  localparam int unsigned SET_CNT  = 2 ** IDX_W;
  localparam int unsigned TAG_W    = VPN_W - IDX_W;
  localparam int unsigned WAY_W    = $clog2(WAY_TOTAL);
  localparam int unsigned HALF     = WAY_TOTAL / 2;

  localparam logic ACT_LOOKUP  = 1'b0;
  localparam logic ACT_INSTALL = 1'b1;

  localparam logic [CORE_W-1:0] CORE_PRIMARY = '0;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [PFN_W-1:0]   frame;
    logic [CORE_W-1:0]  owner;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef entry_t [WAY_TOTAL-1:0] row_t;

  localparam int unsigned ROW_W = $bits(row_t);

endpackage

### design/cpltlb_ram.sv
// ----------------------------------------------------------------------------
// cpltlb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpltlb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/core_partitioned_lru_tlb_core.sv
// ----------------------------------------------------------------------------
// core_partitioned_lru_tlb_core
// Set-associative TLB with ways split between core 0 and the other cores,
// least-recently-stamped replacement.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfers at a rising edge with start_i high and busy_o low.
//   action_i selects lookup or install. The set row is read from RAM at
//   that edge; in the next cycle (busy_o high) the row is matched, the
//   victim chosen and the modified row written back.
//   A lookup gives one result: result_valid_o is high for exactly one cycle,
//   registered at the end of the busy cycle, with hit_o and phys_frame_out_o.
//   An install gives no result.
//   No new request is taken while busy_o is high: the RAM read of a row is
//   followed by the read-modify-write of the same row.
//   The receiver cannot stall; results are never held.
//   Reset clears all valid and dirty bits and the access counters; tag,
//   frame, owner and stamp fields need no clearing since invalid entries
//   are never matched.
// ----------------------------------------------------------------------------
module core_partitioned_lru_tlb_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           action_i,
  input  logic [cpltlb_pkg::VPN_W-1:0]   virt_page_i,
  input  logic [cpltlb_pkg::PFN_W-1:0]   phys_frame_in_i,
  input  logic                           write_access_i,
  input  logic [cpltlb_pkg::CORE_W-1:0]  core_sel_i,
  input  logic [cpltlb_pkg::STAMP_W-1:0] time_stamp_i,
  output logic                           result_valid_o,
  output logic                           hit_o,
  output logic [cpltlb_pkg::PFN_W-1:0]   phys_frame_out_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  logic state_q, state_d;
  logic accept;

  logic                             act_q;
  logic [cpltlb_pkg::IDX_W-1:0]     set_q;
  logic [cpltlb_pkg::TAG_W-1:0]     tag_q;
  logic [cpltlb_pkg::PFN_W-1:0]     frame_q;
  logic                             wr_q;
  logic [cpltlb_pkg::CORE_W-1:0]    core_q;
  logic [cpltlb_pkg::STAMP_W-1:0]   stamp_q;

  logic [cpltlb_pkg::SET_CNT-1:0][cpltlb_pkg::WAY_TOTAL-1:0] valid_q;
  logic [cpltlb_pkg::SET_CNT-1:0][cpltlb_pkg::WAY_TOTAL-1:0] dirty_q;

  logic [cpltlb_pkg::CNT_W-1:0] rd_lookups_q, rd_misses_q;
  logic [cpltlb_pkg::CNT_W-1:0] wr_lookups_q, wr_misses_q;

  logic                         res_vld_q;
  logic                         hit_q;
  logic [cpltlb_pkg::PFN_W-1:0] frame_out_q;

  logic [cpltlb_pkg::ROW_W-1:0] ram_rdata;
  cpltlb_pkg::row_t             rd_row, wr_row;
  logic                         ram_we;

  logic [cpltlb_pkg::WAY_TOTAL-1:0] in_rng, hit_vec, inv_vec, set_valid;
  logic                             hit_any, inv_any;
  logic [cpltlb_pkg::WAY_W-1:0]     hit_way, inv_way, lru_way, way_sel;
  logic [cpltlb_pkg::STAMP_W-1:0]   lru_stamp;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q == S_LOOK);

  cpltlb_ram #(
    .WIDTH (cpltlb_pkg::ROW_W),
    .DEPTH (cpltlb_pkg::SET_CNT),
    .AW    (cpltlb_pkg::IDX_W)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (set_q),
    .wdata_i (wr_row),
    .re_i    (accept),
    .raddr_i (virt_page_i[cpltlb_pkg::IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_row    = cpltlb_pkg::row_t'(ram_rdata);
  assign set_valid = valid_q[set_q];

  always_comb begin
    for (int w = 0; w < cpltlb_pkg::WAY_TOTAL; w++) begin
      in_rng[w]  = (core_q == cpltlb_pkg::CORE_PRIMARY) ? (w < cpltlb_pkg::HALF)
                                                         : (w >= cpltlb_pkg::HALF);
      hit_vec[w] = set_valid[w] && in_rng[w] && (rd_row[w].tag == tag_q)
                   && (rd_row[w].owner == core_q);
      inv_vec[w] = in_rng[w] && !set_valid[w];
    end
    hit_any = 1'b0;
    inv_any = 1'b0;
    hit_way = '0;
    inv_way = '0;
    for (int w = cpltlb_pkg::WAY_TOTAL - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_any = 1'b1;
        hit_way = cpltlb_pkg::WAY_W'(w);
      end
      if (inv_vec[w]) begin
        inv_any = 1'b1;
        inv_way = cpltlb_pkg::WAY_W'(w);
      end
    end
    lru_way   = (core_q == cpltlb_pkg::CORE_PRIMARY) ? '0
                                                     : cpltlb_pkg::WAY_W'(cpltlb_pkg::HALF);
    lru_stamp = rd_row[lru_way].stamp;
    for (int w = 0; w < cpltlb_pkg::WAY_TOTAL; w++) begin
      if (in_rng[w] && (rd_row[w].stamp < lru_stamp)) begin
        lru_way   = cpltlb_pkg::WAY_W'(w);
        lru_stamp = rd_row[w].stamp;
      end
    end
    way_sel = hit_any ? hit_way : (inv_any ? inv_way : lru_way);

    wr_row = rd_row;
    if (act_q == cpltlb_pkg::ACT_INSTALL) begin
      wr_row[way_sel].tag   = tag_q;
      wr_row[way_sel].frame = frame_q;
      wr_row[way_sel].owner = core_q;
      wr_row[way_sel].stamp = stamp_q;
    end else begin
      wr_row[hit_way].stamp = stamp_q;
    end
    ram_we = (state_q == S_LOOK) && ((act_q == cpltlb_pkg::ACT_INSTALL) || hit_any);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_LOOK;
      S_LOOK:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= action_i;
      set_q   <= virt_page_i[cpltlb_pkg::IDX_W-1:0];
      tag_q   <= virt_page_i[cpltlb_pkg::VPN_W-1:cpltlb_pkg::IDX_W];
      frame_q <= phys_frame_in_i;
      wr_q    <= write_access_i;
      core_q  <= core_sel_i;
      stamp_q <= time_stamp_i;
    end
    if (state_q == S_LOOK) begin
      hit_q       <= hit_any;
      frame_out_q <= hit_any ? rd_row[hit_way].frame : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_vld_q    <= 1'b0;
      valid_q      <= '0;
      dirty_q      <= '0;
      rd_lookups_q <= '0;
      rd_misses_q  <= '0;
      wr_lookups_q <= '0;
      wr_misses_q  <= '0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= (state_q == S_LOOK) && (act_q == cpltlb_pkg::ACT_LOOKUP);
      if (state_q == S_LOOK) begin
        if (act_q == cpltlb_pkg::ACT_INSTALL) begin
          valid_q[set_q][way_sel] <= 1'b1;
          dirty_q[set_q][way_sel] <= wr_q;
        end else if (wr_q) begin
          wr_lookups_q <= wr_lookups_q + 1'b1;
          if (!hit_any) wr_misses_q <= wr_misses_q + 1'b1;
        end else begin
          rd_lookups_q <= rd_lookups_q + 1'b1;
          if (!hit_any) rd_misses_q <= rd_misses_q + 1'b1;
        end
      end
    end
  end

  assign result_valid_o   = res_vld_q;
  assign hit_o            = hit_q;
  assign phys_frame_out_o = frame_out_q;

`ifndef SYNTHESIS
  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("busy held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("transfer not followed by busy cycle");

  a_result_from_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(busy_o) && ($past(act_q) == cpltlb_pkg::ACT_LOOKUP)))
    else $error("result strobe without a lookup");

  a_miss_zero_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !hit_o) |-> (phys_frame_out_o == '0))
    else $error("miss with nonzero frame");

  a_no_write_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && (act_q == cpltlb_pkg::ACT_LOOKUP) && !hit_any) |-> !ram_we)
    else $error("row written on lookup miss");
`endif

endmodule
